// ----- rtl/wav_pkg.sv -----
package wav_pkg;

	typedef enum logic [12:0] {
		PH_RIFF      = 13'h0001,
		PH_SIZE      = 13'h0002,
		PH_WAVE      = 13'h0004,
		PH_ID        = 13'h0008,
		PH_LEN_FMT   = 13'h0010,
		PH_LEN_DATA  = 13'h0020,
		PH_LEN_OTHER = 13'h0040,
		PH_FMT       = 13'h0080,
		PH_SKIP      = 13'h0100,
		PH_DATA      = 13'h0200,
		PH_TAIL      = 13'h0400,
		PH_ERROR     = 13'h0800,
		PH_IDLE      = 13'h1000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_FORMAT = 2'd1,
		KIND_ERROR  = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_NOT_RIFF    = 4'd1;
	localparam logic [3:0] ERR_BAD_SIZE    = 4'd2;
	localparam logic [3:0] ERR_OVERRUN     = 4'd3;
	localparam logic [3:0] ERR_FMT_SHORT   = 4'd4;
	localparam logic [3:0] ERR_NOT_PCM16   = 4'd5;
	localparam logic [3:0] ERR_NO_DATA     = 4'd6;
	localparam logic [3:0] ERR_PREMATURE   = 4'd7;
	localparam logic [3:0] ERR_BAD_CHANNEL = 4'd8;

	localparam logic [0:0] REG_READ_CHANNEL = 1'b0;
	localparam logic [0:0] REG_FILE_SIZE    = 1'b1;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_MIN_LEN     = 32'd16;
	localparam logic [31:0] PCM_FORMAT_TAG  = 32'd1;
	localparam logic [31:0] PCM_BITS        = 32'd16;
	localparam logic [31:0] CHUNK_HDR_LEN   = 32'd8;
	localparam logic [31:0] WAVE_TAG_LEN    = 32'd4;
	localparam logic [15:0] DEFAULT_CHANNELS = 16'd1;
	localparam logic [31:0] DEFAULT_RATE    = 32'd44100;
	localparam logic [31:0] FILE_SIZE_RESET = 32'hFFFF_FFFF;

endpackage

// ----- rtl/wav_pcm16_stream_parser.sv -----
// Byte-stream RIFF/WAVE parser for 16-bit PCM. One file byte is taken per clock while the
// output is not stalled: each item is captured in an input register, and the whole parse step
// (tag compare, little-endian length collection, 32-bit chunk bookkeeping, frame position)
// runs combinationally from the input register into the result register. A new byte is taken
// as the last one leaves the input register, so the sustained rate is one byte per clock.
// The input is held off only while a byte waits behind a result that out_stall keeps at the
// output. A byte gives at most one result.
// start_of_file restarts parsing at that byte; after an error or end_of_file the block
// stays silent until the next start_of_file. The user must write read_channel and file_size
// only while the block is idle; the block itself does not enforce this.
module wav_pcm16_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               start_of_file,
	input  logic               end_of_file,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic signed [15:0] sample,
	output logic               data_end,
	output logic [15:0]        channel_count,
	output logic [31:0]        sample_rate,
	output logic [3:0]         error_code
);

	logic [15:0] read_channel_q;
	logic [31:0] file_size_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;
	logic       eof_s1;
	logic       advance;

	wav_pkg::phase_t phase_q, cur_phase, nxt_phase;
	logic [3:0]  fbi_q, cur_fbi, nxt_fbi;
	logic [31:0] shift_q, cur_shift, nxt_shift;
	logic [31:0] riff_q, cur_riff, nxt_riff;
	logic [31:0] chunk_q, cur_chunk, nxt_chunk;
	logic [15:0] chan_q, cur_chan, nxt_chan;
	logic [31:0] rate_q, cur_rate, nxt_rate;
	logic [16:0] fpos_q, cur_fpos, nxt_fpos;
	logic [7:0]  low_q, cur_low, nxt_low;
	logic        found_q, cur_found, nxt_found;

	logic            res_valid;
	wav_pkg::kind_t  res_kind;
	logic [3:0]      res_code;
	logic [15:0]     res_sample;
	logic            res_dend;

	logic        tw_done;
	logic [31:0] tw_word;
	logic [31:0] byte_w;
	logic [31:0] rl8;
	logic [31:0] riff_after;
	logic [31:0] chunk_dec;
	logic [31:0] fmt_word;
	logic [16:0] off;
	logic [16:0] stride;
	logic [17:0] p1;
	logic [17:0] off1;
	logic        is_err;

	logic               out_valid_q;
	wav_pkg::kind_t     kind_q;
	logic [15:0]        sample_q;
	logic               dend_q;
	logic [15:0]        chan_out_q;
	logic [31:0]        rate_out_q;
	logic [3:0]         code_q;

	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_channel_q <= '0;
			file_size_q    <= wav_pkg::FILE_SIZE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				wav_pkg::REG_READ_CHANNEL: read_channel_q <= cfg_data[15:0];
				wav_pkg::REG_FILE_SIZE:    file_size_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			sof_s1  <= start_of_file;
			eof_s1  <= end_of_file;
		end
	end

	always_comb begin
		// A start mark clears the parse state before this byte is looked at.
		cur_phase = sof_s1 ? wav_pkg::PH_RIFF : phase_q;
		cur_fbi   = sof_s1 ? 4'd0 : fbi_q;
		cur_shift = sof_s1 ? 32'd0 : shift_q;
		cur_riff  = sof_s1 ? 32'd0 : riff_q;
		cur_chunk = sof_s1 ? 32'd0 : chunk_q;
		cur_chan  = sof_s1 ? wav_pkg::DEFAULT_CHANNELS : chan_q;
		cur_rate  = sof_s1 ? wav_pkg::DEFAULT_RATE : rate_q;
		cur_fpos  = sof_s1 ? 17'd0 : fpos_q;
		cur_low   = sof_s1 ? 8'd0 : low_q;
		cur_found = sof_s1 ? 1'b0 : found_q;

		nxt_phase = cur_phase;
		nxt_fbi   = cur_fbi;
		nxt_shift = cur_shift;
		nxt_riff  = cur_riff;
		nxt_chunk = cur_chunk;
		nxt_chan  = cur_chan;
		nxt_rate  = cur_rate;
		nxt_fpos  = cur_fpos;
		nxt_low   = cur_low;
		nxt_found = cur_found;

		res_valid  = 1'b0;
		res_kind   = wav_pkg::KIND_SAMPLE;
		res_code   = wav_pkg::ERR_NONE;
		res_sample = 16'd0;
		res_dend   = 1'b0;

		byte_w  = {24'd0, byte_s1};
		tw_done = (cur_fbi[1:0] == 2'd3);
		tw_word = (cur_fbi[1:0] == 2'd0) ? byte_w
			: (cur_shift | (byte_w << {cur_fbi[1:0], 3'b000}));

		rl8        = cur_riff - wav_pkg::CHUNK_HDR_LEN;
		riff_after = rl8 - tw_word;
		chunk_dec  = cur_chunk - 32'd1;

		case (cur_fbi)
			4'd0, 4'd2, 4'd4, 4'd14: fmt_word = byte_w;
			4'd1, 4'd3, 4'd15:       fmt_word = cur_shift | {16'd0, byte_s1, 8'd0};
			4'd5:                    fmt_word = cur_shift | {16'd0, byte_s1, 8'd0};
			4'd6:                    fmt_word = cur_shift | {8'd0, byte_s1, 16'd0};
			4'd7:                    fmt_word = cur_shift | {byte_s1, 24'd0};
			default:                 fmt_word = cur_shift;
		endcase

		off    = {read_channel_q, 1'b0};
		stride = {cur_chan, 1'b0};
		p1     = {1'b0, cur_fpos} + 18'd1;
		off1   = {1'b0, off} + 18'd1;

		case (cur_phase)
			wav_pkg::PH_RIFF: begin
				nxt_shift = tw_word;
				nxt_fbi   = tw_done ? 4'd0 : cur_fbi + 4'd1;
				if (tw_done) begin
					if (tw_word != wav_pkg::TAG_RIFF) begin
						res_valid = 1'b1;
						res_kind  = wav_pkg::KIND_ERROR;
						res_code  = wav_pkg::ERR_NOT_RIFF;
					end else begin
						nxt_phase = wav_pkg::PH_SIZE;
					end
				end
			end
			wav_pkg::PH_SIZE: begin
				nxt_shift = tw_word;
				nxt_fbi   = tw_done ? 4'd0 : cur_fbi + 4'd1;
				if (tw_done) begin
					if (tw_word < wav_pkg::WAVE_TAG_LEN ||
						({1'b0, tw_word} + {1'b0, wav_pkg::CHUNK_HDR_LEN}) >
						{1'b0, file_size_q}) begin
						res_valid = 1'b1;
						res_kind  = wav_pkg::KIND_ERROR;
						res_code  = wav_pkg::ERR_BAD_SIZE;
					end else begin
						nxt_riff  = tw_word - wav_pkg::WAVE_TAG_LEN;
						nxt_phase = wav_pkg::PH_WAVE;
					end
				end
			end
			wav_pkg::PH_WAVE: begin
				nxt_shift = tw_word;
				nxt_fbi   = tw_done ? 4'd0 : cur_fbi + 4'd1;
				if (tw_done) begin
					if (tw_word != wav_pkg::TAG_WAVE) begin
						res_valid = 1'b1;
						res_kind  = wav_pkg::KIND_ERROR;
						res_code  = wav_pkg::ERR_BAD_SIZE;
					end else begin
						nxt_phase = (cur_riff > wav_pkg::CHUNK_HDR_LEN)
							? wav_pkg::PH_ID : wav_pkg::PH_TAIL;
					end
				end
			end
			wav_pkg::PH_ID: begin
				nxt_shift = tw_word;
				nxt_fbi   = tw_done ? 4'd0 : cur_fbi + 4'd1;
				if (tw_done) begin
					if (tw_word == wav_pkg::TAG_FMT) begin
						nxt_phase = wav_pkg::PH_LEN_FMT;
					end else if (tw_word == wav_pkg::TAG_DATA) begin
						nxt_phase = wav_pkg::PH_LEN_DATA;
					end else begin
						nxt_phase = wav_pkg::PH_LEN_OTHER;
					end
				end
			end
			wav_pkg::PH_LEN_FMT, wav_pkg::PH_LEN_DATA, wav_pkg::PH_LEN_OTHER: begin
				nxt_shift = tw_word;
				nxt_fbi   = tw_done ? 4'd0 : cur_fbi + 4'd1;
				if (tw_done) begin
					nxt_riff = rl8;
					if (tw_word > rl8) begin
						res_valid = 1'b1;
						res_kind  = wav_pkg::KIND_ERROR;
						res_code  = wav_pkg::ERR_OVERRUN;
					end else begin
						nxt_riff  = riff_after;
						nxt_chunk = tw_word;
						if (cur_phase == wav_pkg::PH_LEN_FMT) begin
							if (tw_word < wav_pkg::FMT_MIN_LEN) begin
								res_valid = 1'b1;
								res_kind  = wav_pkg::KIND_ERROR;
								res_code  = wav_pkg::ERR_FMT_SHORT;
							end else begin
								nxt_phase = wav_pkg::PH_FMT;
							end
						end else if (cur_phase == wav_pkg::PH_LEN_DATA) begin
							if (read_channel_q >= cur_chan) begin
								res_valid = 1'b1;
								res_kind  = wav_pkg::KIND_ERROR;
								res_code  = wav_pkg::ERR_BAD_CHANNEL;
							end else begin
								nxt_found = 1'b1;
								nxt_fpos  = 17'd0;
								if (tw_word == 32'd0) begin
									res_valid = 1'b1;
									res_kind  = wav_pkg::KIND_END;
									res_dend  = 1'b1;
									nxt_phase = (riff_after > wav_pkg::CHUNK_HDR_LEN)
										? wav_pkg::PH_ID : wav_pkg::PH_TAIL;
								end else begin
									nxt_phase = wav_pkg::PH_DATA;
								end
							end
						end else begin
							if (tw_word == 32'd0) begin
								nxt_phase = (riff_after > wav_pkg::CHUNK_HDR_LEN)
									? wav_pkg::PH_ID : wav_pkg::PH_TAIL;
							end else begin
								nxt_phase = wav_pkg::PH_SKIP;
							end
						end
					end
				end
			end
			wav_pkg::PH_FMT: begin
				nxt_shift = fmt_word;
				nxt_chunk = chunk_dec;
				nxt_fbi   = cur_fbi + 4'd1;
				if (cur_fbi == 4'd1 && fmt_word != wav_pkg::PCM_FORMAT_TAG) begin
					res_valid = 1'b1;
					res_kind  = wav_pkg::KIND_ERROR;
					res_code  = wav_pkg::ERR_NOT_PCM16;
				end
				if (cur_fbi == 4'd3) begin
					nxt_chan = fmt_word[15:0];
				end
				if (cur_fbi == 4'd7) begin
					nxt_rate = fmt_word;
				end
				if (cur_fbi == 4'd15) begin
					nxt_fbi = 4'd0;
					if (fmt_word != wav_pkg::PCM_BITS) begin
						res_valid = 1'b1;
						res_kind  = wav_pkg::KIND_ERROR;
						res_code  = wav_pkg::ERR_NOT_PCM16;
					end else begin
						res_valid = 1'b1;
						res_kind  = wav_pkg::KIND_FORMAT;
						if (chunk_dec == 32'd0) begin
							nxt_phase = (cur_riff > wav_pkg::CHUNK_HDR_LEN)
								? wav_pkg::PH_ID : wav_pkg::PH_TAIL;
						end else begin
							nxt_phase = wav_pkg::PH_SKIP;
						end
					end
				end
			end
			wav_pkg::PH_SKIP: begin
				nxt_chunk = chunk_dec;
				if (chunk_dec == 32'd0) begin
					nxt_fbi   = 4'd0;
					nxt_phase = (cur_riff > wav_pkg::CHUNK_HDR_LEN)
						? wav_pkg::PH_ID : wav_pkg::PH_TAIL;
				end
			end
			wav_pkg::PH_DATA: begin
				if (cur_fpos == off) begin
					nxt_low = byte_s1;
				end else if ({1'b0, cur_fpos} == off1) begin
					nxt_shift = {16'd0, byte_s1, cur_low};
				end
				if (p1 >= {1'b0, stride}) begin
					if (off1 < {1'b0, stride}) begin
						res_valid  = 1'b1;
						res_kind   = wav_pkg::KIND_SAMPLE;
						res_sample = nxt_shift[15:0];
					end
					nxt_fpos = 17'd0;
				end else begin
					nxt_fpos = p1[16:0];
				end
				nxt_chunk = chunk_dec;
				if (chunk_dec == 32'd0) begin
					res_dend = 1'b1;
					if (!res_valid) begin
						res_valid = 1'b1;
						res_kind  = wav_pkg::KIND_END;
					end
					nxt_fbi   = 4'd0;
					nxt_phase = (cur_riff > wav_pkg::CHUNK_HDR_LEN)
						? wav_pkg::PH_ID : wav_pkg::PH_TAIL;
				end
			end
			default: ;
		endcase

		is_err = res_valid && (res_kind == wav_pkg::KIND_ERROR);
		if (is_err) begin
			nxt_phase = wav_pkg::PH_ERROR;
		end

		// The end mark overrides this byte's result when the walk is unfinished
		// or no data chunk came.
		if (eof_s1) begin
			if (nxt_phase != wav_pkg::PH_ERROR && nxt_phase != wav_pkg::PH_IDLE) begin
				if (nxt_phase != wav_pkg::PH_TAIL) begin
					res_valid  = 1'b1;
					res_kind   = wav_pkg::KIND_ERROR;
					res_code   = wav_pkg::ERR_PREMATURE;
					res_sample = 16'd0;
					res_dend   = 1'b0;
				end else if (!nxt_found) begin
					res_valid  = 1'b1;
					res_kind   = wav_pkg::KIND_ERROR;
					res_code   = wav_pkg::ERR_NO_DATA;
					res_sample = 16'd0;
					res_dend   = 1'b0;
				end
			end
			nxt_phase = wav_pkg::PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wav_pkg::PH_RIFF;
			fbi_q   <= '0;
			shift_q <= '0;
			riff_q  <= '0;
			chunk_q <= '0;
			chan_q  <= wav_pkg::DEFAULT_CHANNELS;
			rate_q  <= wav_pkg::DEFAULT_RATE;
			fpos_q  <= '0;
			low_q   <= '0;
			found_q <= 1'b0;
		end else if (advance) begin
			phase_q <= nxt_phase;
			fbi_q   <= nxt_fbi;
			shift_q <= nxt_shift;
			riff_q  <= nxt_riff;
			chunk_q <= nxt_chunk;
			chan_q  <= nxt_chan;
			rate_q  <= nxt_rate;
			fpos_q  <= nxt_fpos;
			low_q   <= nxt_low;
			found_q <= nxt_found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			kind_q     <= res_kind;
			sample_q   <= res_sample;
			dend_q     <= res_dend;
			chan_out_q <= nxt_chan;
			rate_out_q <= nxt_rate;
			code_q     <= res_code;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign sample        = sample_q;
	assign data_end      = dend_q;
	assign channel_count = chan_out_q;
	assign sample_rate   = rate_out_q;
	assign error_code    = code_q;

endmodule

// ----- rtl/wav_checker.sv -----
module wav_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         kind,
	input logic signed [15:0] sample,
	input logic               data_end,
	input logic [3:0]         error_code
);

	// A stalled result must not change until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(sample)
			&& $stable(error_code))
		else $error("stalled result changed");

	// Only error results carry a code, and every error carries one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == wav_pkg::KIND_ERROR) == (error_code != wav_pkg::ERR_NONE)))
		else $error("error code does not match result kind");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != wav_pkg::KIND_SAMPLE |-> sample == 16'sd0)
		else $error("sample nonzero on a non-sample result");

	// The end of a data chunk is only flagged on sample or end results.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_end |-> kind == wav_pkg::KIND_SAMPLE || kind == wav_pkg::KIND_END)
		else $error("data end on a format or error result");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= wav_pkg::ERR_BAD_CHANNEL)
		else $error("error code out of range");

endmodule

bind wav_pcm16_stream_parser wav_checker u_wav_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.kind       (kind),
	.sample     (sample),
	.data_end   (data_end),
	.error_code (error_code)
);

// ----- tb/sv/wav_stream_checker.sv -----
module wav_stream_checker
	import wav_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               start_of_file,
	input  logic               end_of_file,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         kind,
	input  logic signed [15:0] sample,
	input  logic               data_end,
	input  logic [15:0]        channel_count,
	input  logic [31:0]        sample_rate,
	input  logic [3:0]         error_code,
	output int                 fail_count,
	output int                 results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] sample;
		logic        data_end;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [3:0]  error_code;
	} parse_result_t;

	// Register copies.
	logic [15:0] sel_channel;
	logic [31:0] size_limit;

	// Parser state.
	phase_t      phase;
	logic [3:0]  byte_idx;
	logic [31:0] shift_reg;
	logic [31:0] riff_left;
	logic [31:0] chunk_left;
	logic [15:0] chans;
	logic [31:0] rate;
	logic [16:0] frame_pos;
	logic [7:0]  low_hold;
	logic        data_seen;

	parse_result_t parse_results_q[$];

	function automatic void restart();
		phase = PH_RIFF;
		byte_idx = 4'd0;
		shift_reg = '0;
		riff_left = '0;
		chunk_left = '0;
		chans = DEFAULT_CHANNELS;
		rate = DEFAULT_RATE;
		frame_pos = '0;
		low_hold = '0;
		data_seen = 1'b0;
	endfunction

	// Adds a predicted result at the tail of the expected list.
	function automatic void queue_result(input parse_result_t r);
		parse_results_q.insert(parse_results_q.size(), r);
	endfunction

	// Gathers a little-endian word; true once its fourth byte is in.
	function automatic logic take_word(input logic [7:0] b);
		logic [1:0] i;
		i = byte_idx[1:0];
		if (i == 2'd0)
			shift_reg = {24'd0, b};
		else
			shift_reg |= {24'd0, b} << (8 * i);
		if (i == 2'd3) begin
			byte_idx = 4'd0;
			return 1'b1;
		end
		byte_idx = {2'b00, i} + 4'd1;
		return 1'b0;
	endfunction

	function automatic void chunk_done();
		byte_idx = 4'd0;
		phase = (riff_left > CHUNK_HDR_LEN) ? PH_ID : PH_TAIL;
	endfunction

	function automatic logic parse_byte(input logic [7:0] b, input logic sof, input logic eof,
			output parse_result_t r);
		logic        have;
		kind_t       k;
		logic [3:0]  code;
		logic [15:0] smp;
		logic        dend;
		logic [31:0] len;
		logic [31:0] off;
		logic [31:0] stride;
		logic [31:0] p;
		logic [3:0]  i;
		have = 1'b0;
		k = KIND_SAMPLE;
		code = ERR_NONE;
		smp = '0;
		dend = 1'b0;
		if (sof)
			restart();
		case (phase)
			PH_RIFF: if (take_word(b)) begin
				if (shift_reg != TAG_RIFF) begin
					have = 1'b1; k = KIND_ERROR; code = ERR_NOT_RIFF;
				end else
					phase = PH_SIZE;
			end
			PH_SIZE: if (take_word(b)) begin
				if (shift_reg < WAVE_TAG_LEN ||
						({1'b0, shift_reg} + {1'b0, CHUNK_HDR_LEN}) > {1'b0, size_limit}) begin
					have = 1'b1; k = KIND_ERROR; code = ERR_BAD_SIZE;
				end else begin
					riff_left = shift_reg - WAVE_TAG_LEN;
					phase = PH_WAVE;
				end
			end
			PH_WAVE: if (take_word(b)) begin
				if (shift_reg != TAG_WAVE) begin
					have = 1'b1; k = KIND_ERROR; code = ERR_BAD_SIZE;
				end else
					chunk_done();
			end
			PH_ID: if (take_word(b)) begin
				if (shift_reg == TAG_FMT)
					phase = PH_LEN_FMT;
				else if (shift_reg == TAG_DATA)
					phase = PH_LEN_DATA;
				else
					phase = PH_LEN_OTHER;
			end
			PH_LEN_FMT, PH_LEN_DATA, PH_LEN_OTHER: if (take_word(b)) begin
				len = shift_reg;
				riff_left -= CHUNK_HDR_LEN;
				if (len > riff_left) begin
					have = 1'b1; k = KIND_ERROR; code = ERR_OVERRUN;
				end else begin
					riff_left -= len;
					chunk_left = len;
					if (phase == PH_LEN_FMT) begin
						if (len < FMT_MIN_LEN) begin
							have = 1'b1; k = KIND_ERROR; code = ERR_FMT_SHORT;
						end else begin
							byte_idx = 4'd0;
							phase = PH_FMT;
						end
					end else if (phase == PH_LEN_DATA) begin
						if (sel_channel >= chans) begin
							have = 1'b1; k = KIND_ERROR; code = ERR_BAD_CHANNEL;
						end else begin
							data_seen = 1'b1;
							frame_pos = '0;
							if (len == 0) begin
								have = 1'b1; k = KIND_END; dend = 1'b1;
								chunk_done();
							end else
								phase = PH_DATA;
						end
					end else begin
						if (len == 0)
							chunk_done();
						else
							phase = PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				// Body offsets: tag at 0, channels at 2, rate at 4..7, bit depth at 14.
				i = byte_idx;
				case (i)
					4'd0, 4'd2, 4'd4, 4'd14: shift_reg = {24'd0, b};
					4'd1, 4'd3, 4'd15:       shift_reg |= {16'd0, b, 8'd0};
					4'd5, 4'd6, 4'd7:        shift_reg |= {24'd0, b} << (8 * (i - 4));
					default: ;
				endcase
				chunk_left -= 32'd1;
				if (i == 4'd1 && shift_reg != PCM_FORMAT_TAG) begin
					have = 1'b1; k = KIND_ERROR; code = ERR_NOT_PCM16;
				end else begin
					if (i == 4'd3)
						chans = shift_reg[15:0];
					if (i == 4'd7)
						rate = shift_reg;
					if (i == 4'd15) begin
						if (shift_reg != PCM_BITS) begin
							have = 1'b1; k = KIND_ERROR; code = ERR_NOT_PCM16;
						end else begin
							have = 1'b1; k = KIND_FORMAT;
							if (chunk_left == 0)
								chunk_done();
							else
								phase = PH_SKIP;
						end
					end else
						byte_idx = i + 4'd1;
				end
			end
			PH_SKIP: begin
				chunk_left -= 32'd1;
				if (chunk_left == 0)
					chunk_done();
			end
			PH_DATA: begin
				off = {15'd0, sel_channel, 1'b0};
				stride = {15'd0, chans, 1'b0};
				p = {15'd0, frame_pos};
				if (p == off)
					low_hold = b;
				else if (p == off + 32'd1)
					shift_reg = {16'd0, b, low_hold};
				if (p + 32'd1 >= stride) begin
					if (off + 32'd1 < stride) begin
						have = 1'b1; k = KIND_SAMPLE; smp = shift_reg[15:0];
					end
					frame_pos = '0;
				end else
					frame_pos = p[16:0] + 17'd1;
				chunk_left -= 32'd1;
				if (chunk_left == 0) begin
					dend = 1'b1;
					if (!have) begin
						have = 1'b1; k = KIND_END;
					end
					chunk_done();
				end
			end
			default: ;
		endcase

		if (have && k == KIND_ERROR)
			phase = PH_ERROR;

		// The end mark overrides this byte's result when the walk is unfinished or no data chunk came.
		if (eof && phase != PH_ERROR && phase != PH_IDLE) begin
			if (phase != PH_TAIL) begin
				have = 1'b1; k = KIND_ERROR; code = ERR_PREMATURE; smp = '0; dend = 1'b0;
			end else if (!data_seen) begin
				have = 1'b1; k = KIND_ERROR; code = ERR_NO_DATA; smp = '0; dend = 1'b0;
			end
			phase = PH_IDLE;
		end else if (eof)
			phase = PH_IDLE;

		r = '{k, smp, dend, chans, rate, code};
		return have;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_result_t want_r;
		parse_result_t next_r;
		if (!arst_n) begin
			sel_channel = '0;
			size_limit = FILE_SIZE_RESET;
			restart();
			parse_results_q.delete();
			results_owed = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_READ_CHANNEL)
					sel_channel = cfg_data[15:0];
				else
					size_limit = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (parse_results_q.size() == 0) begin
					$error("result item with none outstanding: kind %0d code %0d", kind,
						error_code);
					fail_count++;
				end else begin
					want_r = parse_results_q.pop_front();
					check_field("kind", want_r.kind, kind);
					check_field("sample", {16'd0, want_r.sample}, {16'd0, sample});
					check_field("data_end", want_r.data_end, data_end);
					check_field("channel_count", want_r.channel_count, channel_count);
					check_field("sample_rate", want_r.sample_rate, sample_rate);
					check_field("error_code", want_r.error_code, error_code);
				end
			end
			if (in_valid && !in_stall) begin
				if (parse_byte(data_byte, start_of_file, end_of_file, next_r))
					queue_result(next_r);
			end
			results_owed = parse_results_q.size();
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wav_pkg::*;

	typedef enum int {
		FLAW_NONE,
		FLAW_NOT_RIFF,
		FLAW_SIZE_SMALL,
		FLAW_SIZE_BIG,
		FLAW_NOT_WAVE,
		FLAW_OVERRUN,
		FLAW_FMT_SHORT,
		FLAW_FMT_TAG,
		FLAW_FMT_BITS,
		FLAW_NO_FMT,
		FLAW_FMT_AFTER,
		FLAW_NO_DATA,
		FLAW_TRUNCATED,
		FLAW_NO_EOF,
		FLAW_NOISE,
		FLAW_CHAN_ZERO
	} flaw_t;

	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [0:0]         cfg_index = REG_READ_CHANNEL;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte = '0;
	logic               start_of_file = 1'b0;
	logic               end_of_file = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         kind;
	logic signed [15:0] sample;
	logic               data_end;
	logic [15:0]        channel_count;
	logic [31:0]        sample_rate;
	logic [3:0]         error_code;
	int                 fail_count;
	int                 results_owed;

	logic [7:0]  wave_bytes[$];
	logic [31:0] riff_field;
	int          burst_left = 0;
	int          items_sent = 0;
	int          files_sent = 0;
	int          hold_count = 0;

	always #5 clk = ~clk;

	wav_pcm16_stream_parser u_dut (.*);

	wav_stream_checker u_check (.*);

	initial begin
		#(5ms);
		$display("wav_pcm16_stream_parser: mismatch");
		$finish;
	end

	// Output side: stall pattern changes every so often; a hold request forces a long stall.
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       hold_seen;
		mode = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_count != hold_seen) begin
				hold_seen = hold_count;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(RX_FREE, RX_PERIODIC));
					mode_left = $urandom_range(10, 150);
				end
				mode_left--;
				case (mode)
					RX_FREE:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:  out_stall <= (mode_left % 4 == 0);
				endcase
			end
		end
	end

	function automatic void append_byte(input logic [7:0] b);
		wave_bytes.insert(wave_bytes.size(), b);
	endfunction

	function automatic logic [7:0] pick_data_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void put_word(input logic [31:0] w, input int nbytes);
		for (int k = 0; k < nbytes; k++)
			append_byte(w[8*k +: 8]);
	endfunction

	function automatic void put_other_chunk();
		int n;
		n = $urandom_range(0, 6);
		put_word($urandom, 4);
		put_word(n, 4);
		repeat (n) append_byte(8'($urandom));
	endfunction

	function automatic void put_fmt_chunk(input flaw_t flaw, input logic [15:0] chans,
			input logic [31:0] rate);
		int          extra;
		logic [15:0] tag;
		logic [15:0] bits;
		put_word(TAG_FMT, 4);
		if (flaw == FLAW_FMT_SHORT) begin
			extra = $urandom_range(0, 15);
			put_word(extra, 4);
			repeat (extra) append_byte(8'($urandom));
			return;
		end
		extra = $urandom_range(0, 4);
		tag = PCM_FORMAT_TAG[15:0];
		bits = PCM_BITS[15:0];
		if (flaw == FLAW_FMT_TAG)
			tag = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
		if (flaw == FLAW_FMT_BITS)
			bits = $urandom_range(0, 1) ? 16'd8 : 16'($urandom_range(17, 65535));
		put_word(FMT_MIN_LEN + extra, 4);
		put_word(tag, 2);
		put_word(chans, 2);
		put_word(rate, 4);
		put_word(rate * chans * 2, 4);
		put_word(chans * 2, 2);
		put_word(bits, 2);
		repeat (extra) append_byte(8'($urandom));
	endfunction

	function automatic void put_data_chunk(input logic [15:0] chans, input int frames);
		int len;
		if (chans == 0 || chans > 8)
			len = frames;
		else begin
			len = 2 * chans * frames;
			// Now and then a partial frame at the end of the chunk.
			if ($urandom_range(0, 3) == 0)
				len += $urandom_range(1, 2 * chans - 1);
		end
		put_word(TAG_DATA, 4);
		put_word(len, 4);
		repeat (len) append_byte(pick_data_byte());
	endfunction

	task automatic build_file(input flaw_t flaw, input logic [15:0] chans,
			input logic [31:0] rate, input int frames);
		int          n;
		logic [31:0] over_len;
		wave_bytes.delete();
		if (flaw == FLAW_NOISE) begin
			n = $urandom_range(1, 30);
			repeat (n) append_byte(8'($urandom));
			return;
		end
		if (flaw == FLAW_CHAN_ZERO)
			chans = 16'd0;
		put_word(TAG_RIFF, 4);
		put_word(32'd0, 4);
		put_word(TAG_WAVE, 4);
		if ($urandom_range(0, 3) == 0)
			put_other_chunk();
		if (flaw != FLAW_NO_FMT && flaw != FLAW_FMT_AFTER)
			put_fmt_chunk(flaw, chans, rate);
		if (flaw != FLAW_NO_DATA) begin
			put_data_chunk(chans, frames);
			if ($urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 1) == 0)
					put_other_chunk();
				put_data_chunk(chans, $urandom_range(0, 3));
			end
		end
		if (flaw == FLAW_FMT_AFTER)
			put_fmt_chunk(FLAW_NONE, chans, rate);
		// Up to eight bytes inside the RIFF size end the walk without another chunk.
		n = $urandom_range(0, 8);
		repeat (n) append_byte(8'($urandom));
		riff_field = wave_bytes.size() - 8;
		if (flaw == FLAW_SIZE_SMALL)
			riff_field = $urandom_range(0, 3);
		if (flaw == FLAW_SIZE_BIG)
			riff_field = 32'hFFFF_FFF8 + $urandom_range(0, 7);
		for (int k = 0; k < 4; k++)
			wave_bytes[4 + k] = riff_field[8*k +: 8];
		if (flaw == FLAW_OVERRUN) begin
			over_len = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF :
				riff_field - 32'd12 + $urandom_range(1, 255);
			for (int k = 0; k < 4; k++)
				wave_bytes[16 + k] = over_len[8*k +: 8];
		end
		if (flaw == FLAW_NOT_RIFF) begin
			n = $urandom_range(0, 3);
			wave_bytes[n] = wave_bytes[n] ^ 8'($urandom_range(1, 255));
		end
		if (flaw == FLAW_NOT_WAVE) begin
			n = $urandom_range(8, 11);
			wave_bytes[n] = wave_bytes[n] ^ 8'($urandom_range(1, 255));
		end
		// Bytes past the RIFF size are ignored by the walk.
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
		if (flaw == FLAW_TRUNCATED) begin
			n = $urandom_range(1, wave_bytes.size() - 1);
			repeat (n) void'(wave_bytes.pop_back());
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(input logic [7:0] b, input logic sof, input logic eof);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		start_of_file <= sof;
		end_of_file <= eof;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_file(input logic with_sof, input logic with_eof);
		int n;
		foreach (wave_bytes[k])
			send_item(wave_bytes[k], with_sof && k == 0,
				with_eof && k == wave_bytes.size() - 1);
		if (with_eof && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) send_item(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
		end
		files_sent++;
		// The next file keeps coming while the output is held off, so the block backs up.
		if (files_sent % 10 == 5)
			hold_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic [15:0] channel, input logic [31:0] size_bytes);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= REG_READ_CHANNEL;
		cfg_data <= {16'd0, channel};
		@(negedge clk);
		cfg_index <= REG_FILE_SIZE;
		cfg_data <= size_bytes;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		flaw_t       flaw;
		logic [15:0] chan_sel;
		logic [15:0] chans;
		logic [31:0] size_sel;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Register reset values; the first file after reset has no start mark.
		build_file(FLAW_NONE, 16'd1, DEFAULT_RATE, 3);
		send_file(1'b0, 1'b1);
		for (int f = FLAW_NONE; f <= FLAW_CHAN_ZERO; f++) begin
			build_file(flaw_t'(f), 16'd2, $urandom, 1);
			send_file(1'b1, f != FLAW_NO_EOF);
		end

		// RIFF size check right at the limit, then one byte short of it.
		build_file(FLAW_NONE, 16'd2, $urandom, 2);
		set_config(16'd1, riff_field + 32'd8);
		send_file(1'b1, 1'b1);
		set_config(16'd1, riff_field + 32'd7);
		send_file(1'b1, 1'b1);

		set_config(16'd0, 32'd0);
		build_file(FLAW_NONE, 16'd1, $urandom, 1);
		send_file(1'b1, 1'b1);

		set_config(16'hFFFF, FILE_SIZE_RESET);
		build_file(FLAW_NONE, 16'd2, $urandom, 1);
		send_file(1'b1, 1'b1);
		build_file(FLAW_NO_DATA, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send_file(1'b1, 1'b1);

		set_config(16'd0, FILE_SIZE_RESET);
		build_file(FLAW_NONE, 16'd1, 32'd0, 6);
		send_file(1'b1, 1'b1);

		// Random files: mostly well formed, with a share of broken ones and noise.
		while (items_sent < 2000) begin
			chan_sel = $urandom_range(0, 3);
			size_sel = ($urandom_range(0, 9) < 7) ? FILE_SIZE_RESET : $urandom_range(40, 200);
			set_config(chan_sel, size_sel);
			repeat ($urandom_range(3, 8)) begin
				flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE :
					flaw_t'($urandom_range(FLAW_NOT_RIFF, FLAW_CHAN_ZERO));
				chans = ($urandom_range(0, 4) != 0) ? chan_sel + 16'($urandom_range(1, 3)) :
					16'($urandom_range(0, 4));
				build_file(flaw, chans, ($urandom_range(0, 3) == 0) ? DEFAULT_RATE : $urandom,
					$urandom_range(0, 12));
				send_file(1'b1, flaw != FLAW_NO_EOF);
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("wav_pcm16_stream_parser: match");
		else
			$display("wav_pcm16_stream_parser: mismatch");
		$finish;
	end

endmodule
